[rtl/c2v_pkg.sv]
// Shared types and constants for the streaming 3x3 valid-region correlator.
package c2v_pkg;

    // Kernel and window geometry
    localparam int MAX_KERNEL = 3;
    localparam int LINE_ROWS  = MAX_KERNEL - 1;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int CNT_W      = 10;
    localparam int DIM_W      = 11;
    localparam int KDIM_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SUM_W      = 14;

    // Position counters wrap at this count
    localparam int CNT_LIMIT = 1024;

    // Per-tap modulo by reciprocal multiplication: q = (p * MOD_RECIP) >> MOD_SHIFT
    // is exact for every 16-bit product.
    localparam int          PROD_W    = 2 * PIX_W;
    localparam int unsigned TAP_MOD   = 1000;
    localparam int unsigned MOD_RECIP = 67109;
    localparam int          MOD_SHIFT = 26;
    localparam int          MUL_W     = 33;
    localparam int          QUO_W     = MUL_W - MOD_SHIFT;
    localparam int          REM_W     = 10;
    localparam int          COL_SUM_W = 12;

    // Output buffer
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int CREDIT_W    = $clog2(OFIFO_DEPTH + 1);

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COEFF_TOP    = 3'd0;
    localparam t_cfg_idx CFG_COEFF_MID    = 3'd1;
    localparam t_cfg_idx CFG_COEFF_BOTTOM = 3'd2;
    localparam t_cfg_idx CFG_KERNEL_H     = 3'd3;
    localparam t_cfg_idx CFG_KERNEL_W     = 3'd4;
    localparam t_cfg_idx CFG_IMAGE_W      = 3'd5;
    localparam t_cfg_idx CFG_IMAGE_H      = 3'd6;

    typedef logic [PIX_W-1:0] t_pix;

    // One window column, element 0 is the oldest row
    typedef logic [MAX_KERNEL-1:0][PIX_W-1:0]  t_column;
    typedef logic [MAX_KERNEL-1:0][COEF_W-1:0] t_coef_col;

    // Per-word bookkeeping that rides along the arithmetic pipeline
    typedef struct packed {
        logic             emit;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             frame_end;
    } t_meta;

    // One result word
    typedef struct packed {
        logic [SUM_W-1:0] filtered;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             frame_end;
    } t_result;

endpackage

[rtl/c2v_cell.sv]
// Window column cell: holds one column of pixels and reduces its three taps mod 1000.
module c2v_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_shift,
    input  c2v_pkg::t_column                  i_col,
    input  c2v_pkg::t_coef_col                i_coef,
    output c2v_pkg::t_column                  o_col,
    output logic [c2v_pkg::COL_SUM_W-1:0]     o_sum
);
    import c2v_pkg::*;

    t_column                             r_col;
    t_column                             n_col;
    logic [MAX_KERNEL-1:0][PROD_W-1:0]   r_prod;
    logic [MAX_KERNEL-1:0][PROD_W-1:0]   r_prod_d;
    logic [MAX_KERNEL-1:0][QUO_W-1:0]    r_quo;
    logic [MAX_KERNEL-1:0][REM_W-1:0]    r_rem;
    logic [COL_SUM_W-1:0]                r_sum;
    logic [MAX_KERNEL-1:0][MUL_W-1:0]    w_mul;
    logic [MAX_KERNEL-1:0][PROD_W-1:0]   w_rem_full;
    logic [COL_SUM_W-1:0]                w_sum;

    // Take the neighbor's column when a new word enters the window
    assign n_col = i_shift ? i_col : r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    // Reciprocal estimate of the quotient and the remainder
    always_comb begin
        for (int k = 0; k < MAX_KERNEL; k++) begin
            w_mul[k]      = MUL_W'(r_prod[k]) * MUL_W'(MOD_RECIP);
            w_rem_full[k] = r_prod_d[k] - PROD_W'(r_quo[k]) * PROD_W'(TAP_MOD);
        end
    end

    // Add the reduced taps of the column
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < MAX_KERNEL; k++) begin
            w_sum = w_sum + COL_SUM_W'(r_rem[k]);
        end
    end

    // Product, quotient, remainder and column sum stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_KERNEL; k++) begin
            r_prod[k]   <= PROD_W'(r_col[k]) * PROD_W'(i_coef[k]);
            r_prod_d[k] <= r_prod[k];
            r_quo[k]    <= w_mul[k][MUL_W-1:MOD_SHIFT];
            r_rem[k]    <= w_rem_full[k][REM_W-1:0];
        end
        r_sum <= w_sum;
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

[rtl/c2v_line_store.sv]
// Line store: two previous image rows in one memory, with clearing pass and write bypass.
module c2v_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  c2v_pkg::t_pix              i_px,
    output c2v_pkg::t_pix              o_above1,
    output c2v_pkg::t_pix              o_above2,
    output logic                       o_busy
);
    import c2v_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int ENTRY_W = LINE_ROWS * PIX_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic [ENTRY_W-1:0] r_byp_data;
    logic               r_byp;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;
    logic [ENTRY_W-1:0] w_cur;
    logic [ENTRY_W-1:0] w_wdata;

    // Use the word written last cycle when the read hit the same slot
    assign w_cur    = r_byp ? r_byp_data : r_rd;
    assign o_above1 = w_cur[PIX_W-1:0];
    assign o_above2 = w_cur[ENTRY_W-1:PIX_W];
    assign w_wdata  = {o_above1, i_px};
    assign o_busy   = r_clr_busy;

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= w_wdata;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    // Track a read that collides with the write of the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp      <= i_wr_en && (i_rd_addr == i_wr_addr);
            r_byp_data <= w_wdata;
        end
    end

    // Zero every slot once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

endmodule

[rtl/c2v_out_fifo.sv]
// Output buffer: small FIFO of result words that decouples the pipeline from the consumer.
module c2v_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  c2v_pkg::t_result    i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output c2v_pkg::t_result    o_data
);
    import c2v_pkg::*;

    t_result               r_buf [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   r_wp;
    logic [OFIFO_AW-1:0]   r_rp;
    logic [CREDIT_W-1:0]   r_cnt;
    logic [CREDIT_W-1:0]   n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];

    // Count words held
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CREDIT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CREDIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OFIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + OFIFO_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

[rtl/conv2d_valid_mod_product.sv]
// Top level: streaming valid-region 2D correlation, per-tap products reduced mod 1000.
// Throughput: one pixel per cycle while o_in_ready is high, set by the line-store
// read-modify-write and an 8-word output buffer whose credits cover the accept-to-drain
// loop; ready drops when every credit is reserved or while the line store is clearing.
// Reset: synchronous, active low; afterwards the line store is zeroed one slot per
// cycle, min(MAX_WIDTH, 1024) slots (1024 by default), with o_in_ready held low.
module conv2d_valid_mod_product #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [c2v_pkg::PIX_W-1:0]          i_pixel,
    input  logic                               i_frame_start,
    // Result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [c2v_pkg::SUM_W-1:0]          o_filtered,
    output logic [c2v_pkg::CNT_W-1:0]          o_out_row,
    output logic [c2v_pkg::CNT_W-1:0]          o_out_col,
    output logic                               o_frame_end,
    // Configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [c2v_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [c2v_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import c2v_pkg::*;

    localparam int LS_DEPTH = (MAX_WIDTH < CNT_LIMIT) ? MAX_WIDTH : CNT_LIMIT;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int NSTAGE   = 6;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_coeff_top;
    logic [CFG_DATA_W-1:0] r_coeff_mid;
    logic [CFG_DATA_W-1:0] r_coeff_bot;
    logic [KDIM_W-1:0]     r_kh;
    logic [KDIM_W-1:0]     r_kw;
    logic [DIM_W-1:0]      r_iw;
    logic [DIM_W-1:0]      r_ih;

    // Position and pipeline state
    logic [CNT_W-1:0]      r_col;
    logic [CNT_W-1:0]      r_row;
    logic [CNT_W-1:0]      n_col;
    logic [CNT_W-1:0]      n_row;
    logic [NSTAGE-1:0]     r_vld;
    t_meta                 r_meta [NSTAGE];
    t_pix                  r_s1_px;
    logic [LS_AW-1:0]      r_s1_addr;
    logic [CREDIT_W-1:0]   r_credit;
    logic [CREDIT_W-1:0]   n_credit;

    logic                  w_acc;
    logic                  w_cfg_wr;
    logic [KDIM_W-1:0]     w_kh;
    logic [KDIM_W-1:0]     w_kw;
    logic [DIM_W-1:0]      w_w;
    logic [DIM_W-1:0]      w_h;
    logic [CNT_W-1:0]      w_c;
    logic [CNT_W-1:0]      w_r;
    logic [DIM_W-1:0]      w_c1;
    logic [DIM_W-1:0]      w_r1;
    t_meta                 w_meta;
    logic                  w_ls_busy;
    t_pix                  w_above1;
    t_pix                  w_above2;
    t_column               w_new_col;
    t_column               w_col_in  [MAX_KERNEL];
    t_column               w_col_out [MAX_KERNEL];
    t_coef_col             w_coef    [MAX_KERNEL];
    logic [COL_SUM_W-1:0]  w_col_sum [MAX_KERNEL];
    logic [SUM_W-1:0]      w_total;
    logic                  w_push;
    logic                  w_pop;
    t_result               w_push_data;
    t_result               w_out_data;

    assign w_acc    = i_in_valid && o_in_ready;
    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_top <= '0;
            r_coeff_mid <= '0;
            r_coeff_bot <= '0;
            r_kh        <= KDIM_W'(3);
            r_kw        <= KDIM_W'(3);
            r_iw        <= DIM_W'(CNT_LIMIT);
            r_ih        <= DIM_W'(CNT_LIMIT);
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_COEFF_TOP:    r_coeff_top <= i_cfg_data;
                CFG_COEFF_MID:    r_coeff_mid <= i_cfg_data;
                CFG_COEFF_BOTTOM: r_coeff_bot <= i_cfg_data;
                CFG_KERNEL_H:     r_kh        <= i_cfg_data[KDIM_W-1:0];
                CFG_KERNEL_W:     r_kw        <= i_cfg_data[KDIM_W-1:0];
                CFG_IMAGE_W:      r_iw        <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_H:      r_ih        <= i_cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp kernel and image sizes to their legal ranges
    always_comb begin
        w_kh = (r_kh == '0) ? KDIM_W'(1) : r_kh;
        w_kw = (r_kw == '0) ? KDIM_W'(1) : r_kw;
        if (r_iw == '0) begin
            w_w = DIM_W'(1);
        end else if (r_iw > DIM_W'(LS_DEPTH)) begin
            w_w = DIM_W'(LS_DEPTH);
        end else begin
            w_w = r_iw;
        end
        if (r_ih == '0) begin
            w_h = DIM_W'(1);
        end else if (r_ih > DIM_W'(CNT_LIMIT)) begin
            w_h = DIM_W'(CNT_LIMIT);
        end else begin
            w_h = r_ih;
        end
    end

    // Position of the incoming pixel and whether it completes a kernel window
    always_comb begin
        w_c  = i_frame_start ? '0 : r_col;
        w_r  = i_frame_start ? '0 : r_row;
        w_c1 = DIM_W'(w_c) + DIM_W'(1);
        w_r1 = DIM_W'(w_r) + DIM_W'(1);
        w_meta.emit      = (DIM_W'(w_c) < w_w) && (DIM_W'(w_r) < w_h) &&
                           (w_c1 >= DIM_W'(w_kw)) && (w_r1 >= DIM_W'(w_kh));
        w_meta.row       = CNT_W'(w_r1 - DIM_W'(w_kh));
        w_meta.col       = CNT_W'(w_c1 - DIM_W'(w_kw));
        w_meta.frame_end = (w_r1 == w_h) && (w_c1 == w_w);
    end

    // Advance the position counters, wrapping at row and image end
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_acc) begin
            if (w_c1 >= w_w) begin
                n_col = '0;
                n_row = (w_r1 >= w_h) ? '0 : w_r1[CNT_W-1:0];
            end else begin
                n_col = w_c1[CNT_W-1:0];
                n_row = w_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_vld <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_vld <= {r_vld[NSTAGE-2:0], w_acc};
        end
    end

    // Carry word bookkeeping down the pipeline
    always_ff @(posedge i_clk) begin
        r_meta[0] <= w_meta;
        for (int s = 1; s < NSTAGE; s++) begin
            r_meta[s] <= r_meta[s-1];
        end
        if (w_acc) begin
            r_s1_px   <= i_pixel;
            r_s1_addr <= w_c[LS_AW-1:0];
        end
    end

    c2v_line_store #(
        .DEPTH(LS_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_c[LS_AW-1:0]),
        .i_wr_en   (r_vld[0]),
        .i_wr_addr (r_s1_addr),
        .i_px      (r_s1_px),
        .o_above1  (w_above1),
        .o_above2  (w_above2),
        .o_busy    (w_ls_busy)
    );

    // New window column: two stored rows above, current pixel at the bottom
    assign w_new_col[0] = w_above2;
    assign w_new_col[1] = w_above1;
    assign w_new_col[2] = r_s1_px;

    // Coefficient for each window tap; taps outside the kernel get zero
    always_comb begin
        logic [KDIM_W-1:0]     a;
        logic [KDIM_W-1:0]     b;
        logic [CFG_DATA_W-1:0] row_reg;
        for (int j = 0; j < MAX_KERNEL; j++) begin
            for (int k = 0; k < MAX_KERNEL; k++) begin
                a = KDIM_W'(3'(k) + 3'(w_kh) - 3'(MAX_KERNEL));
                b = KDIM_W'(3'(j) + 3'(w_kw) - 3'(MAX_KERNEL));
                case (a)
                    2'd0:    row_reg = r_coeff_top;
                    2'd1:    row_reg = r_coeff_mid;
                    default: row_reg = r_coeff_bot;
                endcase
                if ((3'(k) + 3'(w_kh) >= 3'(MAX_KERNEL)) &&
                    (3'(j) + 3'(w_kw) >= 3'(MAX_KERNEL))) begin
                    w_coef[j][k] = row_reg[{b, 3'b000} +: COEF_W];
                end else begin
                    w_coef[j][k] = '0;
                end
            end
        end
    end

    // Chain of window cells, newest column on the right
    genvar gj;
    generate
        for (gj = 0; gj < MAX_KERNEL; gj++) begin : g_cell
            if (gj == MAX_KERNEL - 1) begin : g_head
                assign w_col_in[gj] = w_new_col;
            end else begin : g_link
                assign w_col_in[gj] = w_col_out[gj+1];
            end
            c2v_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (r_vld[0]),
                .i_col   (w_col_in[gj]),
                .i_coef  (w_coef[gj]),
                .o_col   (w_col_out[gj]),
                .o_sum   (w_col_sum[gj])
            );
        end
    endgenerate

    // Add the column sums
    always_comb begin
        w_total = '0;
        for (int j = 0; j < MAX_KERNEL; j++) begin
            w_total = w_total + SUM_W'(w_col_sum[j]);
        end
    end

    assign w_push                = r_vld[NSTAGE-1] && r_meta[NSTAGE-1].emit;
    assign w_push_data.filtered  = w_total;
    assign w_push_data.row       = r_meta[NSTAGE-1].row;
    assign w_push_data.col       = r_meta[NSTAGE-1].col;
    assign w_push_data.frame_end = r_meta[NSTAGE-1].frame_end;

    c2v_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (o_out_valid),
        .o_data  (w_out_data)
    );

    assign w_pop       = o_out_valid && i_out_ready;
    assign o_filtered  = w_out_data.filtered;
    assign o_out_row   = w_out_data.row;
    assign o_out_col   = w_out_data.col;
    assign o_frame_end = w_out_data.frame_end;

    // Reserve a buffer slot for every result word in flight
    always_comb begin
        n_credit = r_credit;
        if ((w_acc && w_meta.emit) && !w_pop) begin
            n_credit = r_credit + CREDIT_W'(1);
        end else if (!(w_acc && w_meta.emit) && w_pop) begin
            n_credit = r_credit - CREDIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    assign o_in_ready = !w_ls_busy && (r_credit != CREDIT_W'(OFIFO_DEPTH));

    // Checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ls_busy |-> !o_in_ready)
        else $error("pixel accepted during line store clearing");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_W'(OFIFO_DEPTH))
        else $error("output credit count overflow");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_credit != '0))
        else $error("result word shown without a reserved slot");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_meta.emit) |-> ##6 w_push)
        else $error("result word did not reach the output buffer in time");

endmodule

[tb/conv2d_checker.sv]
// Result checker for the valid-region correlator: mirrors the block and compares words.
module conv2d_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Pixel channel
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [c2v_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_frame_start,
    // Result channel
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [c2v_pkg::SUM_W-1:0]      i_filtered,
    input  logic [c2v_pkg::CNT_W-1:0]      i_out_row,
    input  logic [c2v_pkg::CNT_W-1:0]      i_out_col,
    input  logic                           i_frame_end,
    // Setup channel
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [c2v_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [c2v_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Tallies for the top
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import c2v_pkg::*;

    localparam int ROW_LIMIT = CNT_LIMIT;
    localparam int COL_LIMIT = (MAX_WIDTH < CNT_LIMIT) ? MAX_WIDTH : CNT_LIMIT;

    // Shadow copy of the setup registers
    logic [CFG_DATA_W-1:0] coeff_row [3];
    logic [KDIM_W-1:0]     kern_rows;
    logic [KDIM_W-1:0]     kern_cols;
    logic [DIM_W-1:0]      img_cols;
    logic [DIM_W-1:0]      img_rows;

    // Shadow copy of the line buffers, tap window and raster position
    t_pix        line_buf [2*MAX_WIDTH];
    t_pix        taps [9];
    int unsigned col_pos;
    int unsigned row_pos;

    // Result words still owed by the block, oldest first
    t_result     due_sums [$];

    // Push one pixel through the window and work out the word it yields, if any
    task automatic correlate_pixel(input t_pix pix, input logic fs,
                                   output logic hit, output t_result res);
        int unsigned w, h, kh, kw, c, r, slot, sum, a, b, coef;
        t_pix        above1, above2;
        w  = (img_cols == 0) ? 1 : ((img_cols > COL_LIMIT) ? COL_LIMIT : img_cols);
        h  = (img_rows == 0) ? 1 : ((img_rows > ROW_LIMIT) ? ROW_LIMIT : img_rows);
        kh = (kern_rows == 0) ? 1 : kern_rows;
        kw = (kern_cols == 0) ? 1 : kern_cols;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;

        // Rotate the column through the two line buffers
        slot   = c % MAX_WIDTH;
        above1 = line_buf[slot];
        above2 = line_buf[MAX_WIDTH + slot];
        line_buf[MAX_WIDTH + slot] = above1;
        line_buf[slot] = pix;

        // Shift the window left and insert the new column on the right
        for (a = 0; a < 3; a++) begin
            taps[a*3]     = taps[a*3 + 1];
            taps[a*3 + 1] = taps[a*3 + 2];
        end
        taps[2] = above2;
        taps[5] = above1;
        taps[8] = pix;

        hit = (c < w) && (r < h) && (c + 1 >= kw) && (r + 1 >= kh);
        res = '0;
        if (hit) begin
            sum = 0;
            for (a = 0; a < kh; a++) begin
                for (b = 0; b < kw; b++) begin
                    coef = coeff_row[a][8*b +: 8];
                    sum += (coef * taps[(3 - kh + a)*3 + (3 - kw + b)]) % TAP_MOD;
                end
            end
            res.filtered  = SUM_W'(sum);
            res.row       = CNT_W'(r + 1 - kh);
            res.col       = CNT_W'(c + 1 - kw);
            res.frame_end = (r + 1 == h) && (c + 1 == w);
        end

        // Advance the raster position, wrapping at row and image ends
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : ((r + 1) % CNT_LIMIT);
        end else begin
            col_pos = (c + 1) % CNT_LIMIT;
        end
    endtask

    always @(posedge i_clk) begin
        logic    hit;
        t_result res;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            // Hold the shadow state at its reset values
            coeff_row[0] = '0;
            coeff_row[1] = '0;
            coeff_row[2] = '0;
            kern_rows    = 3;
            kern_cols    = 3;
            img_cols     = 1024;
            img_rows     = 1024;
            foreach (line_buf[i]) line_buf[i] = '0;
            foreach (taps[i]) taps[i] = '0;
            col_pos = 0;
            row_pos = 0;
            due_sums.delete();
        end else begin
            // Track setup writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COEFF_TOP:    coeff_row[0] = i_cfg_data;
                    CFG_COEFF_MID:    coeff_row[1] = i_cfg_data;
                    CFG_COEFF_BOTTOM: coeff_row[2] = i_cfg_data;
                    CFG_KERNEL_H:     kern_rows = i_cfg_data[KDIM_W-1:0];
                    CFG_KERNEL_W:     kern_cols = i_cfg_data[KDIM_W-1:0];
                    CFG_IMAGE_W:      img_cols = i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_H:      img_rows = i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end

            // Predict from each accepted pixel word
            if (i_in_valid && i_in_ready) begin
                correlate_pixel(i_pixel, i_frame_start, hit, res);
                if (hit) begin
                    due_sums.push_back(res);
                end
            end

            // Compare each accepted result word with the oldest one owed
            if (i_out_valid && i_out_ready) begin
                got.filtered  = i_filtered;
                got.row       = i_out_row;
                got.col       = i_out_col;
                got.frame_end = i_frame_end;
                if (due_sums.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("mismatch: unexpected word filtered %0d row %0d col %0d end %0b",
                                 got.filtered, got.row, got.col, got.frame_end);
                    end
                end else begin
                    want = due_sums.pop_front();
                    o_checked++;
                    if (got.filtered !== want.filtered || got.row !== want.row ||
                        got.col !== want.col || got.frame_end !== want.frame_end) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $write("mismatch at word %0d (expected/actual): filtered %0d/%0d",
                                   o_checked, want.filtered, got.filtered);
                            $display(" row %0d/%0d col %0d/%0d end %0b/%0b",
                                     want.row, got.row, want.col, got.col,
                                     want.frame_end, got.frame_end);
                        end
                    end
                end
            end
        end
        o_pending = due_sums.size();
    end

endmodule

[tb/testbench.sv]
// Testbench top for the valid-region correlator: clock, reset, stimulus and verdict.
module testbench;
    import c2v_pkg::*;

    localparam int MAX_WIDTH       = 1024;
    localparam int DIRECTED_PIXELS = 23;
    localparam int RANDOM_PIXELS   = 1450;
    localparam int DRAIN_CYCLES    = 16;
    // Covers the line-buffer clearing pass after reset with a wide margin
    localparam int QUIET_LIMIT     = 4000;
    // Index past the last register; the block must ignore writes to it
    localparam t_cfg_idx CFG_UNUSED = 3'd7;
    // Pixels of the full 3x3 directed image, first pixel in the top byte
    localparam logic [71:0] FULL_KERNEL_IMAGE = 72'hFF_00_FF_01_FE_80_FF_FF_00;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_pixel       = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [SUM_W-1:0]      o_filtered;
    logic [CNT_W-1:0]      o_out_row;
    logic [CNT_W-1:0]      o_out_col;
    logic                  o_frame_end;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int mismatches;
    int results_pending;
    int results_checked;
    int pixels_sent  = 0;
    int setups       = 0;
    int quiet_cycles = 0;

    // Sender burst shaping
    int burst_left = 0;
    int burst_max  = 16;
    int gap_max    = 0;

    // Receiver stall pattern
    int sink_phase = 0;
    int stall_left = 0;

    conv2d_valid_mod_product #(.MAX_WIDTH(MAX_WIDTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_filtered    (o_filtered),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_frame_end   (o_frame_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    conv2d_checker #(.MAX_WIDTH(MAX_WIDTH)) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_filtered    (o_filtered),
        .i_out_row     (o_out_row),
        .i_out_col     (o_out_col),
        .i_frame_end   (o_frame_end),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (mismatches),
        .o_pending     (results_pending),
        .o_checked     (results_checked)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel: free-flowing, coin-flip, long stalls, rare stalls
    always @(posedge i_clk) begin
        sink_phase = (sink_phase + 1) % 512;
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (sink_phase / 128)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    if ($urandom_range(0, 9) == 0) begin
                        stall_left = $urandom_range(1, 11);
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    // Count cycles in which no word moves on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("testbench: stalled for %0d cycles", QUIET_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // Place random bits above a register's width; the block must drop them
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                       input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        return (junk << width) | value;
    endfunction

    // Mostly uniform pixels, with the extremes favored
    function automatic t_pix pick_pixel();
        if ($urandom_range(0, 7) == 0) begin
            return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        end
        return t_pix'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coeffs();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Offer one pixel word, opening a gap first when the current burst is spent
    task automatic send_pixel(input t_pix pix, input logic fs);
        if (burst_left == 0) begin
            if (gap_max != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_pixel       <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_in_ready);
        pixels_sent++;
    endtask

    // Offer one setup word and hold it until taken; the caller drops valid
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_setup(input logic [CFG_DATA_W-1:0] top, mid, bottom,
                              input int kh, kw, w, h);
        write_reg(CFG_COEFF_TOP, top);
        write_reg(CFG_COEFF_MID, mid);
        write_reg(CFG_COEFF_BOTTOM, bottom);
        write_reg(CFG_KERNEL_H, with_junk(kh, KDIM_W));
        write_reg(CFG_KERNEL_W, with_junk(kw, KDIM_W));
        write_reg(CFG_IMAGE_W, with_junk(w, DIM_W));
        write_reg(CFG_IMAGE_H, with_junk(h, DIM_W));
        i_cfg_valid <= 1'b0;
        setups++;
    endtask

    // Drop valid, wait for every owed word, then let the pipeline run dry
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                    w, h, kh, kw, area, frames, n, f, i;
        logic                  fs;
        logic [CFG_DATA_W-1:0] rows [3];

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full 3x3 kernel, largest coefficients, extreme pixels: one word
        load_setup('1, '1, '1, 3, 3, 3, 3);
        for (i = 0; i < 9; i++) begin
            send_pixel(FULL_KERNEL_IMAGE[8*(8-i) +: 8], i == 0);
        end
        settle();

        // Zero kernel size as 1x1, oversize width, zero height, then shrink mid-row
        load_setup(24'h5A3CFF, '0, '1, 0, 0, 2047, 0);
        for (i = 0; i < 6; i++) begin
            send_pixel(pick_pixel(), i == 0);
        end
        settle();
        write_reg(CFG_IMAGE_W, with_junk(3, DIM_W));
        write_reg(CFG_UNUSED, '1);
        i_cfg_valid <= 1'b0;
        for (i = 0; i < 4; i++) begin
            send_pixel(pick_pixel(), 1'b0);
        end
        settle();

        // Image narrower than the kernel, oversize height: no words at all
        load_setup(pick_coeffs(), pick_coeffs(), pick_coeffs(), 3, 3, 2, 2047);
        for (i = 0; i < 4; i++) begin
            send_pixel(pick_pixel(), i == 0);
        end
        settle();

        // Random setups, mostly whole frames, some broken streams
        while (pixels_sent < DIRECTED_PIXELS + RANDOM_PIXELS) begin
            for (i = 0; i < 3; i++) begin
                rows[i] = pick_coeffs();
            end
            kh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            kw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            case ($urandom_range(0, 15))
                0:       w = 0;
                1, 2:    w = $urandom_range(40, 80);
                default: w = $urandom_range(1, 12);
            endcase
            h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
            load_setup(rows[0], rows[1], rows[2], kh, kw, w, h);

            case ($urandom_range(0, 2))
                0: begin
                    gap_max   = 0;
                    burst_max = 16;
                end
                1: begin
                    gap_max   = 5;
                    burst_max = 16;
                end
                default: begin
                    gap_max   = 3;
                    burst_max = 4;
                end
            endcase

            area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            if ($urandom_range(0, 7) == 0) begin
                // Broken stream: arbitrary length, stray frame starts
                n = $urandom_range(1, area + 10);
                for (i = 0; i < n; i++) begin
                    send_pixel(pick_pixel(), $urandom_range(0, 15) == 0);
                end
            end else begin
                // Whole frames; later ones often rely on the counters wrapping
                frames = (area > 100) ? 1 : $urandom_range(1, 3);
                for (f = 0; f < frames; f++) begin
                    for (i = 0; i < area; i++) begin
                        if (i != 0) begin
                            fs = 1'b0;
                        end else if (f == 0) begin
                            fs = ($urandom_range(0, 3) != 0);
                        end else begin
                            fs = 1'($urandom_range(0, 1));
                        end
                        send_pixel(pick_pixel(), fs);
                    end
                end
            end
            settle();
        end

        $display("testbench: %0d pixels over %0d setups, %0d result words checked",
                 pixels_sent, setups, results_checked);
        $display("testbench: kernels 1x1..3x3, clamped sizes, mid-image changes, stray starts");
        if (mismatches == 0 && results_pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
